// ----- src/pcreb_pkg.sv -----
// Package: constants, types and SHA-256 helpers for the PCR extend bank.
package pcreb_pkg;

  localparam int unsigned PcrCount   = 16;
  localparam int unsigned WatchedPcr = 10;
  localparam int unsigned DigWords   = 4;
  localparam int unsigned MemDepth   = PcrCount * DigWords;
  localparam int unsigned MemAw      = $clog2(MemDepth);
  localparam int unsigned PcrAw      = $clog2(PcrCount);

  localparam logic [2:0] RegTgtValid = 3'd0;
  localparam logic [2:0] RegTgtW0    = 3'd1;
  localparam logic [2:0] RegTgtW1    = 3'd2;
  localparam logic [2:0] RegTgtW2    = 3'd3;
  localparam logic [2:0] RegTgtW3    = 3'd4;

  typedef logic [31:0] word_t;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLoad  = 7'b0000010,
    StRound = 7'b0000100,
    StFold  = 7'b0001000,
    StWrite = 7'b0010000,
    StOut   = 7'b0100000,
    StBad   = 7'b1000000
  } state_e;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- src/pcr_extend_bank.sv -----
// Top level: SHA-256 PCR extend bank with memory-held registers.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid_i/in_stall_o | pcr_index_i, digest_w0_i..w3_i
//  out     | out | out_valid_o/out_stall_i | value_w0_o..w3_o, now_matches_o,
//          |     |                     | ever_matched_o, bad_index_o
//  cfg     | in  | APB                 | target_valid, target_w0..w3 at 8*i
//
// A request runs from acceptance to a valid result in these steps: read
// four words from the bank memory, two SHA-256 compressions of 64 rounds
// (one round per cycle on a shared round unit) with a fold step after each,
// write-back of four words, then the result register. A bad index skips to
// StBad, which fills the result register with a zero value directly.
// Bank memory is a 64x64 synchronous RAM; after reset a clearing pass
// writes zeros to all 64 words, during which no request is accepted.
// A result holds in the output register until taken; a new request is
// accepted only once the output register is empty.
module pcr_extend_bank
  import pcreb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pcr_index_i,
  input  logic [63:0] digest_w0_i,
  input  logic [63:0] digest_w1_i,
  input  logic [63:0] digest_w2_i,
  input  logic [63:0] digest_w3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_w0_o,
  output logic [63:0] value_w1_o,
  output logic [63:0] value_w2_o,
  output logic [63:0] value_w3_o,
  output logic        now_matches_o,
  output logic        ever_matched_o,
  output logic        bad_index_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---- configuration ----
  logic        tgt_valid_q;
  logic [63:0] tgt_q [4];
  logic [2:0]  reg_sel;
  assign reg_sel = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) tgt_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegTgtValid: tgt_valid_q <= pwdata[0];
        RegTgtW0:    tgt_q[0] <= pwdata;
        RegTgtW1:    tgt_q[1] <= pwdata;
        RegTgtW2:    tgt_q[2] <= pwdata;
        RegTgtW3:    tgt_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegTgtValid: prdata = {63'd0, tgt_valid_q};
      RegTgtW0:    prdata = tgt_q[0];
      RegTgtW1:    prdata = tgt_q[1];
      RegTgtW2:    prdata = tgt_q[2];
      RegTgtW3:    prdata = tgt_q[3];
      default:     prdata = '0;
    endcase
  end

  // ---- bank memory ----
  logic [63:0] mem [MemDepth];
  logic        mem_we;
  logic [MemAw-1:0] mem_wa, mem_ra;
  logic [63:0] mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // ---- control ----
  state_e state_q, state_d;
  logic        clr_busy_q;
  logic [MemAw:0] clr_cnt_q;
  logic [2:0]  wcnt_q;       // word counter for load / write-back
  logic [5:0]  rnd_q;
  logic        blk_q;        // 0: first block, 1: padding block
  logic [PcrAw-1:0] idx_q;
  logic        watch_q;
  word_t       w_q [16];     // message schedule window
  word_t       h_q [8];
  word_t       a_q [8];      // working variables a..h
  logic        seen_q;
  logic        ov_q;
  logic [63:0] val_q [4];
  logic        now_q, bad_q;

  logic accept;
  assign in_stall_o = clr_busy_q || (state_q != StIdle) || ov_q;
  assign accept     = in_valid_i && !in_stall_o;

  // round datapath
  word_t s0, s1, t1, t2, wn;
  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    t1 = a_q[7] + (rotr(a_q[4], 6) ^ rotr(a_q[4], 11) ^ rotr(a_q[4], 25))
       + ((a_q[4] & a_q[5]) ^ (~a_q[4] & a_q[6])) + RoundK[rnd_q] + w_q[0];
    t2 = (rotr(a_q[0], 2) ^ rotr(a_q[0], 13) ^ rotr(a_q[0], 22))
       + ((a_q[0] & a_q[1]) ^ (a_q[0] & a_q[2]) ^ (a_q[1] & a_q[2]));
  end

  logic [63:0] dig [4];
  assign dig[0] = digest_w0_i;
  assign dig[1] = digest_w1_i;
  assign dig[2] = digest_w2_i;
  assign dig[3] = digest_w3_i;

  logic match;
  assign match = watch_q && tgt_valid_q
              && ({h_q[0], h_q[1]} == tgt_q[0]) && ({h_q[2], h_q[3]} == tgt_q[1])
              && ({h_q[4], h_q[5]} == tgt_q[2]) && ({h_q[6], h_q[7]} == tgt_q[3]);

  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_wa  = {idx_q, wcnt_q[1:0]};
    mem_wd  = {h_q[{wcnt_q[1:0], 1'b0}], h_q[{wcnt_q[1:0], 1'b1}]};
    mem_ra  = {idx_q, wcnt_q[1:0]};
    if (clr_busy_q) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q[MemAw-1:0];
      mem_wd = '0;
    end
    case (state_q)
      StIdle:  if (accept) state_d = (pcr_index_i >= 8'(PcrCount)) ? StBad : StLoad;
      StLoad:  if (wcnt_q == 3'd4) state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = StFold;
      StFold:  state_d = blk_q ? StWrite : StRound;
      StWrite: begin
        mem_we = 1'b1;
        if (wcnt_q == 3'd3) state_d = StOut;
      end
      StOut:   state_d = StIdle;
      StBad:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      wcnt_q     <= '0;
      rnd_q      <= '0;
      blk_q      <= 1'b0;
      seen_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (MemAw+1)'(MemDepth - 1)) clr_busy_q <= 1'b0;
      end
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          wcnt_q <= '0;
          rnd_q  <= '0;
          blk_q  <= 1'b0;
        end
        StLoad:  wcnt_q <= (wcnt_q == 3'd4) ? 3'd0 : wcnt_q + 3'd1;
        StRound: rnd_q <= rnd_q + 6'd1;
        StFold:  blk_q <= 1'b1;
        StWrite: wcnt_q <= wcnt_q + 3'd1;
        StOut: begin
          ov_q <= 1'b1;
          if (match) seen_q <= 1'b1;
        end
        StBad:   ov_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (accept) begin
        idx_q   <= pcr_index_i[PcrAw-1:0];
        watch_q <= (pcr_index_i == 8'(WatchedPcr));
        for (int i = 0; i < 4; i++) begin
          w_q[8 + 2*i]     <= dig[i][63:32];
          w_q[8 + 2*i + 1] <= dig[i][31:0];
        end
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= InitH[i];
          a_q[i] <= InitH[i];
        end
      end
      StLoad: if (wcnt_q != 3'd0) begin
        w_q[{wcnt_q[1:0] - 2'd1, 1'b0}] <= mem_rd_q[63:32];
        w_q[{wcnt_q[1:0] - 2'd1, 1'b1}] <= mem_rd_q[31:0];
      end
      StRound: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wn;
        a_q[7] <= a_q[6]; a_q[6] <= a_q[5]; a_q[5] <= a_q[4];
        a_q[4] <= a_q[3] + t1;
        a_q[3] <= a_q[2]; a_q[2] <= a_q[1]; a_q[1] <= a_q[0];
        a_q[0] <= t1 + t2;
      end
      StFold: begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + a_q[i];
          a_q[i] <= h_q[i] + a_q[i];
        end
        for (int i = 0; i < 16; i++) w_q[i] <= '0;
        w_q[0]  <= 32'h80000000;
        w_q[15] <= 32'd512;
      end
      StOut: begin
        for (int i = 0; i < 4; i++) val_q[i] <= {h_q[2*i], h_q[2*i+1]};
        now_q <= match;
        bad_q <= 1'b0;
      end
      StBad: begin
        for (int i = 0; i < 4; i++) val_q[i] <= '0;
        now_q <= 1'b0;
        bad_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = ov_q;
  assign value_w0_o     = val_q[0];
  assign value_w1_o     = val_q[1];
  assign value_w2_o     = val_q[2];
  assign value_w3_o     = val_q[3];
  assign now_matches_o  = now_q;
  assign ever_matched_o = seen_q;
  assign bad_index_o    = bad_q;

endmodule

// ----- src/pcreb_checker.sv -----
// Checker: port-level properties of the PCR extend bank, bound to the top.
module pcreb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       now_matches_o,
  input logic       ever_matched_o,
  input logic       bad_index_o,
  input logic [63:0] value_w0_o
);
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  a_stall_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o) else $error("accepting during clear");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> in_stall_o) else $error("second request accepted while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> !now_matches_o && value_w0_o == 64'd0)
    else $error("bad index result not clean");
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && now_matches_o |-> ever_matched_o) else $error("sticky lost");
endmodule

bind pcr_extend_bank pcreb_checker u_pcreb_checker (.*);
